### rtl/core/radix_integer_to_symbols_core_macros.svh
// Assertion macros shared by the radix conversion core.
`ifndef RADIX_INTEGER_TO_SYMBOLS_CORE_MACROS_SVH
`define RADIX_INTEGER_TO_SYMBOLS_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RITS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define RITS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/core/rits_pkg.sv
// Shared constants, types and helpers of the radix conversion core.
package rits_pkg;

	// Fixed field widths
	localparam int VALUE_W     = 32;
	localparam int SYM_W       = 8;
	localparam int COUNT_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int ALPHA_SIZE  = 16;
	localparam int TAB_W       = ALPHA_SIZE * SYM_W;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;

	// Parameter defaults
	localparam int DEF_MAX_BASE   = 16;
	localparam int DEF_VALUE_BITS = 32;

	// Special symbol bytes
	localparam logic [SYM_W-1:0] PLUS_BYTE  = 8'h2B;
	localparam logic [SYM_W-1:0] MINUS_BYTE = 8'h2D;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	// Alphabet checker status
	typedef struct packed {
		logic done;
		logic ok;
	} check_stat_t;

	// Divider status
	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] rem;
	} div_stat_t;

	// Look up the symbol byte of one digit
	function automatic logic [SYM_W-1:0] sym_of(input logic [TAB_W-1:0] tab,
		input logic [DIGIT_W-1:0] d);
		return tab[{d, 3'b000} +: SYM_W];
	endfunction

endpackage

### rtl/core/rits_if.sv
// Channel interfaces of the radix conversion core.

// Input item channel
interface rits_value_if import rits_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// Output symbol channel
interface rits_symbol_if import rits_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;
	logic             bad_base;

	modport source (output valid, output symbol, output last, output bad_base, input ready);
	modport sink (input valid, input symbol, input last, input bad_base, output ready);
endinterface

// Configuration write channel
interface rits_cfg_if import rits_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/rits_alpha_check.sv
// Alphabet checker: walks the symbols in use, one symbol per cycle.
module rits_alpha_check import rits_pkg::*; #(
	parameter int MAX_BASE = DEF_MAX_BASE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COUNT_W-1:0] digit_count,
	input  logic [TAB_W-1:0]   sym_tab,
	output check_stat_t        stat
);

	logic               busy_q;
	logic               done_q;
	logic               ok_q;
	logic [DIGIT_W-1:0] idx_q;
	logic [SYM_W-1:0]   cur_sym;
	logic               hit;
	logic               count_bad;
	logic               at_end;

	// Compare the current symbol with the sign bytes and every earlier symbol
	always_comb begin
		cur_sym = sym_of(sym_tab, idx_q);
		hit = (cur_sym == PLUS_BYTE) || (cur_sym == MINUS_BYTE);
		for (int j = 0; j < ALPHA_SIZE; j++) begin
			if ((DIGIT_W'(j) < idx_q) && (sym_of(sym_tab, DIGIT_W'(j)) == cur_sym)) begin
				hit = 1'b1;
			end
		end
	end

	assign count_bad = (digit_count < COUNT_W'(2)) || (digit_count > COUNT_W'(MAX_BASE));
	assign at_end    = ({1'b0, idx_q} == (digit_count - COUNT_W'(1)));

	// Step through the alphabet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				idx_q <= '0;
				if (count_bad) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					ok_q   <= 1'b0;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (hit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					ok_q   <= 1'b0;
				end else if (at_end) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					ok_q   <= 1'b1;
				end else begin
					idx_q <= idx_q + DIGIT_W'(1);
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.ok   = ok_q;

endmodule

### rtl/core/rits_divider.sv
// Restoring divider by the base, one quotient bit per cycle.
module rits_divider import rits_pkg::*; #(
	parameter int W = DEF_VALUE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [W-1:0]       dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic [W-1:0]       quotient,
	output div_stat_t          stat
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]       quo_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [COUNT_W-1:0] div_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [COUNT_W-1:0] trial;
	logic [COUNT_W-1:0] diff;
	logic               fits;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - div_q;
	assign fits  = (trial >= div_q);

	// Payload shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

### rtl/core/radix_integer_to_symbols_core.sv
// Top level of the radix conversion core: registers, sequencer, digit stack, output.
// Converts each signed input value into symbol bytes, most significant digit
// first, with a leading '-' for negative values; an invalid alphabet gives one
// result flagged bad_base. One item is in work at a time. An item goes through
// the alphabet check, which looks at most at MAX_BASE symbols, then one pass of
// the shared restoring divider per digit, then a '-' for a negative value, and
// each symbol takes one stack read and one output load. Results wait in an
// output register, and a new item is taken while the last result of the
// previous one waits.
module radix_integer_to_symbols_core import rits_pkg::*; #(
	parameter int MAX_BASE   = DEF_MAX_BASE,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	rits_value_if.sink     item,
	rits_symbol_if.source  sym,
	rits_cfg_if.sink       cfg
);

	`include "radix_integer_to_symbols_core_macros.svh"

	localparam int VB          = VALUE_BITS;
	localparam int STACK_DEPTH = VALUE_BITS;
	localparam int AW          = $clog2(STACK_DEPTH);
	localparam int HB          = $clog2(STACK_DEPTH + 1);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CHECK  = 7'b0000010,
		ST_DIVIDE = 7'b0000100,
		ST_SIGN   = 7'b0001000,
		ST_FETCH  = 7'b0010000,
		ST_EMIT   = 7'b0100000,
		ST_BAD    = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] digit_count_q;
	logic [TAB_W-1:0]   sym_tab_q;
	logic               neg_q;
	logic [VB-1:0]      mag_q;
	logic [HB-1:0]      held_q;
	logic [HB-1:0]      held_inc;
	logic               out_vld_q;
	logic [SYM_W-1:0]   out_sym_q;
	logic               out_last_q;
	logic               out_bad_q;
	logic [DIGIT_W-1:0] stack_mem [STACK_DEPTH];
	logic [DIGIT_W-1:0] stack_rd_q;
	logic [AW-1:0]      stack_ra;

	logic               in_acc;
	logic               out_free;
	logic [VB-1:0]      raw;
	logic [VB-1:0]      raw_neg;
	check_stat_t        chk_stat;
	div_stat_t          div_stat;
	logic               div_start;
	logic [VB-1:0]      div_dividend;
	logic [VB-1:0]      div_quo;
	logic               more_digits;

	assign in_acc   = item.valid && item.ready;
	assign out_free = !out_vld_q || sym.ready;
	assign raw      = item.value[VB-1:0];
	assign raw_neg  = ~raw + VB'(1);
	assign held_inc = held_q + HB'(1);
	assign stack_ra = AW'(held_q - HB'(1));

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			sym_tab_q     <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DIGIT_COUNT:  digit_count_q <= cfg.data[COUNT_W-1:0];
				REG_SYMBOLS_LOW:  sym_tab_q[CFG_DATA_W-1:0] <= cfg.data;
				REG_SYMBOLS_HIGH: sym_tab_q[TAB_W-1:CFG_DATA_W] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Alphabet checker, started with each item
	rits_alpha_check #(
		.MAX_BASE(MAX_BASE)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_acc),
		.digit_count(digit_count_q),
		.sym_tab    (sym_tab_q),
		.stat       (chk_stat)
	);

	// Shared divider: first pass on the magnitude, then on each quotient
	assign more_digits  = (div_quo != '0) && (held_inc < HB'(STACK_DEPTH));
	assign div_start    = ((state_q == ST_CHECK) && chk_stat.done && chk_stat.ok) ||
		((state_q == ST_DIVIDE) && div_stat.done && more_digits);
	assign div_dividend = (state_q == ST_CHECK) ? mag_q : div_quo;

	rits_divider #(
		.W(VB)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (digit_count_q),
		.quotient(div_quo),
		.stat    (div_stat)
	);

	// Digit stack: push remainders, read back in reverse
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIVIDE) && div_stat.done) begin
			stack_mem[held_q[AW-1:0]] <= div_stat.rem;
		end
		stack_rd_q <= stack_mem[stack_ra];
	end

	// Latch sign and magnitude of an accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q <= raw[VB-1];
			mag_q <= raw[VB-1] ? raw_neg : raw;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (chk_stat.done) begin
						held_q  <= '0;
						state_q <= chk_stat.ok ? ST_DIVIDE : ST_BAD;
					end
				end
				ST_DIVIDE: begin
					if (div_stat.done) begin
						held_q <= held_inc;
						if (!more_digits) begin
							state_q <= neg_q ? ST_SIGN : ST_FETCH;
						end
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						held_q  <= held_q - HB'(1);
						state_q <= (held_q == HB'(1)) ? ST_IDLE : ST_FETCH;
					end
				end
				ST_BAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item.ready = (state_q == ST_IDLE);

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free && ((state_q == ST_SIGN) || (state_q == ST_EMIT) ||
			(state_q == ST_BAD))) begin
			out_vld_q <= 1'b1;
		end else if (sym.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				ST_SIGN: begin
					out_sym_q  <= MINUS_BYTE;
					out_last_q <= 1'b0;
					out_bad_q  <= 1'b0;
				end
				ST_EMIT: begin
					out_sym_q  <= sym_of(sym_tab_q, stack_rd_q);
					out_last_q <= (held_q == HB'(1));
					out_bad_q  <= 1'b0;
				end
				ST_BAD: begin
					out_sym_q  <= '0;
					out_last_q <= 1'b1;
					out_bad_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign sym.valid    = out_vld_q;
	assign sym.symbol   = out_sym_q;
	assign sym.last     = out_last_q;
	assign sym.bad_base = out_bad_q;

	// Assertions
	`RITS_ASSERT_NEXT(a_accept_to_check, clk, arst_n, in_acc, state_q == ST_CHECK)
	`RITS_ASSERT_IMPL(a_bad_is_final, clk, arst_n, out_vld_q && out_bad_q, (out_sym_q == '0) && out_last_q)
	`RITS_ASSERT_IMPL(a_div_done_in_divide, clk, arst_n, div_stat.done, state_q == ST_DIVIDE)
	`RITS_ASSERT_IMPL(a_held_in_range, clk, arst_n, 1'b1, held_q <= HB'(STACK_DEPTH))

endmodule
